// File: design/cpu_time_slice_scheduler_assert.svh
// Assertion macros shared by the scheduler RTL.
// Depends on a clock named clock and a synchronous reset named reset in scope.
`ifndef CPU_TIME_SLICE_SCHEDULER_ASSERT_SVH
`define CPU_TIME_SLICE_SCHEDULER_ASSERT_SVH

// Checked on every clock edge outside reset.
`define CTSS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define CTSS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: design/ctss_pkg.sv
// Shared types, codes and helper functions of the time-slice scheduler.
// No dependencies; imported by cpu_time_slice_scheduler.
package ctss_pkg;

   localparam int MAX_PROC   = 8;
   localparam int MAX_LEVELS = 8;
   localparam int PROC_W     = $clog2(MAX_PROC);
   localparam int LVL_W      = $clog2(MAX_LEVELS);
   localparam int CNT_W      = $clog2(MAX_PROC + 1);
   localparam int LIST_AW    = LVL_W + PROC_W;
   localparam int TIME_W     = 12;
   localparam int VAL_W      = 8;
   localparam int NUM_W      = TIME_W + 2;
   localparam int DEN_W      = VAL_W + 1;
   localparam int PROD_W     = NUM_W + DEN_W + 1;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   // Scheduling policy codes.
   localparam logic [2:0] POL_FCFS     = 3'd0;
   localparam logic [2:0] POL_RR       = 3'd1;
   localparam logic [2:0] POL_SPN      = 3'd2;
   localparam logic [2:0] POL_HRRN     = 3'd3;
   localparam logic [2:0] POL_MLFQ_FIX = 3'd4;
   localparam logic [2:0] POL_MLFQ_EXP = 3'd5;
   localparam logic [2:0] POL_STRIDE   = 3'd6;
   localparam logic [2:0] POL_SPARE    = 3'd7;

   // Request kinds.
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_POLICY  = 2'd0;
   localparam logic [1:0] CSR_QUANTUM = 2'd1;
   localparam logic [1:0] CSR_COUNT   = 2'd2;

   // One process table entry.
   typedef struct packed {
      logic [TIME_W-1:0] first_run;
      logic [VAL_W-1:0]  remaining;
      logic [VAL_W-1:0]  tickets;
      logic [VAL_W-1:0]  service;
      logic [VAL_W-1:0]  arrival;
   } proc_entry_type;

   localparam int ENTRY_W = $bits(proc_entry_type);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ARR_RD,
      ST_ARR_CHK,
      ST_PREP,
      ST_PICK,
      ST_MLFQ_RD,
      ST_SC_LRD,
      ST_SC_PRD,
      ST_SC_MUL,
      ST_SC_CMP,
      ST_RUN_RD,
      ST_RUN_WR,
      ST_RM_RD,
      ST_RM_WR,
      ST_OUT
   } state_type;

   // Slice length for a policy at a feedback level.
   function automatic logic [VAL_W-1:0] quantum_for(input logic [2:0] pol,
                                                    input logic [LVL_W-1:0] lvl,
                                                    input logic [VAL_W-1:0] q);
      logic [VAL_W-1:0] r;
      if (pol == POL_MLFQ_EXP) begin
         if ({1'b0, lvl} >= (LVL_W + 1)'(VAL_W)) begin
            r = '1;
         end else begin
            r = VAL_W'(1) << lvl;
         end
      end else begin
         r = (q == '0) ? VAL_W'(1) : q;
      end
      return r;
   endfunction

endpackage

// File: design/ctss_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
module ctss_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: design/cpu_time_slice_scheduler.sv
// CPU time-slice scheduler. A load request (tuser 0) stores one process entry
// and returns no response. A tick request (tuser 1) runs one time unit and
// returns one response. A tick is worked out by a sequencer around two RAMs
// with registered reads (process table, ready lists): a read and an arrival
// check per taking-part process, then requeue and pick; when a choice is
// scanned, a list read, a table read, a cross multiply and a compare per
// ready-list entry; a read and a write to update the running process; when one
// is taken out of a list, a read and a write per entry moved, then the count
// drops; last the response is sent. Requests are taken one at a time; a
// finished response waits in the output register while the next request is
// accepted.
// Depends on ctss_pkg, ctss_ram and cpu_time_slice_scheduler_assert.svh.
`include "cpu_time_slice_scheduler_assert.svh"

module cpu_time_slice_scheduler
   import ctss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // proc_index[2:0], arrival[10:3], service[18:11],
                                    // tickets[26:19], zero[31:27]
   input  logic        req_tuser,   // kind[0]
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // slot_time[11:0], running_proc[14:12], finished[15],
                                    // first_run_time[27:16], all_done[28], zero[31:29]
   output logic        rsp_tuser,   // idle[0]
   // Configuration port.
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [7:0]  csr_wdata
);

   state_type state_ff, state_in;

   logic [2:0]        policy_ff, policy_in;
   logic [VAL_W-1:0]  quantum_ff, quantum_in;
   logic [3:0]        count_ff, count_in;

   logic [MAX_PROC-1:0] started_ff, started_in;
   logic [MAX_PROC-1:0] done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff [MAX_LEVELS];
   logic [CNT_W-1:0]    cnt_in [MAX_LEVELS];
   logic [PROC_W-1:0]   cur_ff, cur_in;
   logic [LVL_W-1:0]    level_ff, level_in;
   logic [VAL_W-1:0]    slice_ff, slice_in;
   logic [TIME_W-1:0]   tick_ff, tick_in;
   logic                held_ff, held_in;

   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [PROC_W-1:0]   pos_ff, pos_in;
   logic [LVL_W-1:0]    rm_lvl_ff, rm_lvl_in;
   logic [PROC_W-1:0]   run_proc_ff, run_proc_in;
   logic                ran_ff, ran_in;
   logic                fin_ff, fin_in;
   logic [TIME_W-1:0]   frt_ff, frt_in;

   logic [PROC_W-1:0]        cand_ff, cand_in;
   logic [PROC_W-1:0]        best_proc_ff, best_proc_in;
   logic signed [NUM_W-1:0]  best_num_ff, best_num_in;
   logic [DEN_W-1:0]         best_den_ff, best_den_in;
   logic signed [NUM_W-1:0]  cand_num_ff, cand_num_in;
   logic [DEN_W-1:0]         cand_den_ff, cand_den_in;
   logic signed [PROD_W-1:0] prod_a_ff, prod_a_in;
   logic signed [PROD_W-1:0] prod_b_ff, prod_b_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_data_ff, rsp_data_in;
   logic              rsp_idle_ff, rsp_idle_in;

   // RAM ports.
   logic                 pr_we;
   logic [PROC_W-1:0]    pr_waddr, pr_raddr;
   proc_entry_type       pr_wdata, pr_rdata;
   logic                 lr_we;
   logic [LIST_AW-1:0]   lr_waddr, lr_raddr;
   logic [PROC_W-1:0]    lr_wdata, lr_rdata;

   // Helpers.
   logic [2:0]           pol;
   logic                 preempt;
   logic                 is_mlfq;
   logic [CNT_W-1:0]     n_eff;
   logic                 any_wait;
   logic                 mlfq_hit;
   logic [LVL_W-1:0]     mlfq_lvl;
   logic [MAX_PROC-1:0]  part_mask;
   logic                 push_en;
   logic [LVL_W-1:0]     push_lvl;
   logic [PROC_W-1:0]    push_val;
   logic                 better;
   logic                 take_cand;
   logic                 rm_need;
   logic                 run_fin;
   logic [PROC_W-1:0]    req_index;
   logic [VAL_W-1:0]     req_arrival, req_service, req_tickets;
   logic [LVL_W-1:0]     down_lvl;
   logic [CNT_W-1:0]     idx_next;
   proc_entry_type       run_entry;
   logic signed [NUM_W-1:0] cnum;
   logic [DEN_W-1:0]        cden;

   ctss_ram #(.DATA_W(ENTRY_W), .DEPTH(MAX_PROC)) u_proc_ram (
      .clock   (clock),
      .wr_en   (pr_we),
      .wr_addr (pr_waddr),
      .wr_data (pr_wdata),
      .rd_addr (pr_raddr),
      .rd_data (pr_rdata)
   );

   ctss_ram #(.DATA_W(PROC_W), .DEPTH(MAX_LEVELS * MAX_PROC)) u_list_ram (
      .clock   (clock),
      .wr_en   (lr_we),
      .wr_addr (lr_waddr),
      .wr_data (lr_wdata),
      .rd_addr (lr_raddr),
      .rd_data (lr_rdata)
   );

   assign req_index   = req_tdata[2:0];
   assign req_arrival = req_tdata[10:3];
   assign req_service = req_tdata[18:11];
   assign req_tickets = req_tdata[26:19];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_idle_ff;

   // Policy decode and queue summaries.
   always_comb begin
      pol     = (policy_ff == POL_SPARE) ? POL_FCFS : policy_ff;
      preempt = (pol == POL_RR) || (pol == POL_MLFQ_FIX) || (pol == POL_MLFQ_EXP);
      is_mlfq = (pol == POL_MLFQ_FIX) || (pol == POL_MLFQ_EXP);
      n_eff   = (count_ff > 4'(MAX_PROC)) ? CNT_W'(MAX_PROC) : CNT_W'(count_ff);
      any_wait = 1'b0;
      mlfq_hit = 1'b0;
      mlfq_lvl = '0;
      for (int l = MAX_LEVELS - 1; l >= 0; l--) begin
         if (cnt_ff[l] != '0) begin
            any_wait = 1'b1;
            mlfq_hit = 1'b1;
            mlfq_lvl = LVL_W'(l);
         end
      end
      for (int i = 0; i < MAX_PROC; i++) begin
         part_mask[i] = (CNT_W'(i) < n_eff);
      end
      down_lvl = (level_ff == LVL_W'(MAX_LEVELS - 1)) ? level_ff : level_ff + 1'b1;
      idx_next = idx_ff + 1'b1;
   end

   // Sort key of the candidate entry as a fraction num/den.
   always_comb begin
      cnum = '0;
      cden = DEN_W'(1);
      unique case (pol)
         POL_SPN: begin
            cnum = NUM_W'(pr_rdata.remaining);
         end
         POL_HRRN: begin
            cnum = $signed({2'b00, tick_ff}) - $signed({(NUM_W - VAL_W)'(0), pr_rdata.arrival});
            cden = (pr_rdata.service == '0) ? DEN_W'(1) : DEN_W'(pr_rdata.service);
         end
         POL_STRIDE: begin
            cnum = (pr_rdata.service > pr_rdata.remaining) ?
                   NUM_W'(pr_rdata.service - pr_rdata.remaining) : '0;
            cden = (pr_rdata.tickets == '0) ? DEN_W'(1) : DEN_W'(pr_rdata.tickets);
         end
         default: begin
            cnum = '0;
            cden = DEN_W'(1);
         end
      endcase
      unique case (pol)
         POL_HRRN:            better = prod_a_ff > prod_b_ff;
         POL_SPN, POL_STRIDE: better = prod_a_ff < prod_b_ff;
         default:             better = 1'b0;
      endcase
      take_cand = (idx_ff == '0) || better;
   end

   // Sequencer: next state, RAM accesses and state updates.
   always_comb begin
      state_in     = state_ff;
      policy_in    = policy_ff;
      quantum_in   = quantum_ff;
      count_in     = count_ff;
      started_in   = started_ff;
      done_in      = done_ff;
      cnt_in       = cnt_ff;
      cur_in       = cur_ff;
      level_in     = level_ff;
      slice_in     = slice_ff;
      tick_in      = tick_ff;
      held_in      = held_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      rm_lvl_in    = rm_lvl_ff;
      run_proc_in  = run_proc_ff;
      ran_in       = ran_ff;
      fin_in       = fin_ff;
      frt_in       = frt_ff;
      cand_in      = cand_ff;
      best_proc_in = best_proc_ff;
      best_num_in  = best_num_ff;
      best_den_in  = best_den_ff;
      cand_num_in  = cand_num_ff;
      cand_den_in  = cand_den_ff;
      prod_a_in    = prod_a_ff;
      prod_b_in    = prod_b_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_idle_in  = rsp_idle_ff;
      pr_we    = 1'b0;
      pr_waddr = req_index;
      pr_wdata = '0;
      pr_raddr = '0;
      lr_we    = 1'b0;
      lr_waddr = '0;
      lr_wdata = '0;
      lr_raddr = '0;
      push_en  = 1'b0;
      push_lvl = '0;
      push_val = '0;
      rm_need  = 1'b0;
      run_fin  = 1'b0;
      run_entry = pr_rdata;

      // Configuration writes.
      if (csr_we) begin
         unique case (csr_addr)
            CSR_POLICY:  policy_in  = csr_wdata[2:0];
            CSR_QUANTUM: quantum_in = csr_wdata;
            CSR_COUNT:   count_in   = csr_wdata[3:0];
            default:     ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == KIND_LOAD) begin
                  pr_we    = 1'b1;
                  pr_waddr = req_index;
                  pr_wdata = '{first_run: '0, remaining: req_service, tickets: req_tickets,
                               service: req_service, arrival: req_arrival};
                  started_in[req_index] = 1'b0;
                  done_in[req_index]    = 1'b0;
               end else begin
                  idx_in   = '0;
                  state_in = (n_eff == '0) ? ST_PREP : ST_ARR_RD;
               end
            end
         end
         ST_ARR_RD: begin
            pr_raddr = idx_ff[PROC_W-1:0];
            state_in = ST_ARR_CHK;
         end
         ST_ARR_CHK: begin
            // Queue a process that arrives at this tick.
            if ({(TIME_W - VAL_W)'(0), pr_rdata.arrival} == tick_ff) begin
               push_en  = 1'b1;
               push_lvl = '0;
               push_val = idx_ff[PROC_W-1:0];
            end
            idx_in   = idx_next;
            state_in = (idx_next < n_eff) ? ST_ARR_RD : ST_PREP;
         end
         ST_PREP: begin
            // Stride gives the CPU back each tick; a used-up slice is requeued if another waits, else renewed.
            if (pol == POL_STRIDE && held_ff) begin
               push_en  = 1'b1;
               push_lvl = '0;
               push_val = cur_ff;
               held_in  = 1'b0;
            end else if (held_ff && preempt && slice_ff == '0) begin
               if ((pol == POL_RR) ? (cnt_ff[0] != '0) : any_wait) begin
                  push_en  = 1'b1;
                  push_lvl = (pol == POL_RR) ? '0 : down_lvl;
                  push_val = cur_ff;
                  held_in  = 1'b0;
               end else begin
                  slice_in = quantum_for(pol, level_ff, quantum_ff);
               end
            end
            state_in = ST_PICK;
         end
         ST_PICK: begin
            ran_in = 1'b1;
            fin_in = 1'b0;
            if (held_ff) begin
               run_proc_in = cur_ff;
               state_in    = ST_RUN_RD;
            end else if (is_mlfq) begin
               if (mlfq_hit) begin
                  lr_raddr  = {mlfq_lvl, PROC_W'(0)};
                  level_in  = mlfq_lvl;
                  slice_in  = quantum_for(pol, mlfq_lvl, quantum_ff);
                  rm_lvl_in = mlfq_lvl;
                  pos_in    = '0;
                  state_in  = ST_MLFQ_RD;
               end else begin
                  ran_in   = 1'b0;
                  state_in = ST_OUT;
               end
            end else if (cnt_ff[0] != '0) begin
               idx_in   = '0;
               state_in = ST_SC_LRD;
            end else begin
               ran_in   = 1'b0;
               state_in = ST_OUT;
            end
         end
         ST_MLFQ_RD: begin
            run_proc_in = lr_rdata;
            state_in    = ST_RUN_RD;
         end
         ST_SC_LRD: begin
            lr_raddr = {LVL_W'(0), idx_ff[PROC_W-1:0]};
            state_in = ST_SC_PRD;
         end
         ST_SC_PRD: begin
            cand_in  = lr_rdata;
            pr_raddr = lr_rdata;
            state_in = ST_SC_MUL;
         end
         ST_SC_MUL: begin
            // Cross products of the candidate and best keys.
            cand_num_in = cnum;
            cand_den_in = cden;
            prod_a_in   = cnum * $signed({1'b0, best_den_ff});
            prod_b_in   = best_num_ff * $signed({1'b0, cden});
            state_in    = ST_SC_CMP;
         end
         ST_SC_CMP: begin
            if (take_cand) begin
               best_proc_in = cand_ff;
               best_num_in  = cand_num_ff;
               best_den_in  = cand_den_ff;
               pos_in       = idx_ff[PROC_W-1:0];
            end
            idx_in = idx_next;
            if (idx_next < cnt_ff[0]) begin
               state_in = ST_SC_LRD;
            end else begin
               run_proc_in = take_cand ? cand_ff : best_proc_ff;
               rm_lvl_in   = '0;
               if (pol == POL_RR) begin
                  slice_in = quantum_for(pol, '0, quantum_ff);
               end
               state_in = ST_RUN_RD;
            end
         end
         ST_RUN_RD: begin
            pr_raddr = run_proc_ff;
            state_in = ST_RUN_WR;
         end
         ST_RUN_WR: begin
            // Charge one tick to the running process.
            cur_in  = run_proc_ff;
            held_in = (pol != POL_STRIDE);
            if (!started_ff[run_proc_ff]) begin
               run_entry.first_run     = tick_ff;
               started_in[run_proc_ff] = 1'b1;
            end
            run_fin = (run_entry.remaining <= VAL_W'(1));
            if (run_fin) begin
               run_entry.remaining  = '0;
               done_in[run_proc_ff] = 1'b1;
               held_in  = 1'b0;
               slice_in = '0;
            end else begin
               run_entry.remaining = run_entry.remaining - 1'b1;
               if (preempt && slice_ff != '0) begin
                  slice_in = slice_ff - 1'b1;
               end
            end
            pr_we    = 1'b1;
            pr_waddr = run_proc_ff;
            pr_wdata = run_entry;
            fin_in   = run_fin;
            frt_in   = run_entry.first_run;
            rm_need  = (pol == POL_STRIDE) ? run_fin : !held_ff;
            idx_in   = CNT_W'(pos_ff);
            state_in = rm_need ? ST_RM_RD : ST_OUT;
         end
         ST_RM_RD: begin
            // Close the gap left by the removed entry, one move at a time.
            if (idx_next < cnt_ff[rm_lvl_ff]) begin
               lr_raddr = {rm_lvl_ff, idx_next[PROC_W-1:0]};
               state_in = ST_RM_WR;
            end else begin
               cnt_in[rm_lvl_ff] = cnt_ff[rm_lvl_ff] - 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_RM_WR: begin
            lr_we    = 1'b1;
            lr_waddr = {rm_lvl_ff, idx_ff[PROC_W-1:0]};
            lr_wdata = lr_rdata;
            idx_in   = idx_next;
            state_in = ST_RM_RD;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_idle_in  = !ran_ff;
               rsp_data_in  = '0;
               rsp_data_in[11:0]  = tick_ff;
               rsp_data_in[14:12] = ran_ff ? run_proc_ff : '0;
               rsp_data_in[15]    = ran_ff && fin_ff;
               rsp_data_in[27:16] = ran_ff ? frt_ff : '0;
               rsp_data_in[28]    = ((done_ff & part_mask) == part_mask);
               if (tick_ff != TIME_MAX) begin
                  tick_in = tick_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // Shared list append; a full list drops the entry.
      if (push_en && cnt_ff[push_lvl] < CNT_W'(MAX_PROC)) begin
         lr_we    = 1'b1;
         lr_waddr = {push_lvl, cnt_ff[push_lvl][PROC_W-1:0]};
         lr_wdata = push_val;
         cnt_in[push_lvl] = cnt_ff[push_lvl] + 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         policy_ff    <= POL_FCFS;
         quantum_ff   <= VAL_W'(2);
         count_ff     <= 4'd2;
         started_ff   <= '0;
         done_ff      <= '0;
         for (int l = 0; l < MAX_LEVELS; l++) begin
            cnt_ff[l] <= '0;
         end
         cur_ff       <= '0;
         level_ff     <= '0;
         slice_ff     <= '0;
         tick_ff      <= '0;
         held_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         policy_ff    <= policy_in;
         quantum_ff   <= quantum_in;
         count_ff     <= count_in;
         started_ff   <= started_in;
         done_ff      <= done_in;
         cnt_ff       <= cnt_in;
         cur_ff       <= cur_in;
         level_ff     <= level_in;
         slice_ff     <= slice_in;
         tick_ff      <= tick_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      pos_ff       <= pos_in;
      rm_lvl_ff    <= rm_lvl_in;
      run_proc_ff  <= run_proc_in;
      ran_ff       <= ran_in;
      fin_ff       <= fin_in;
      frt_ff       <= frt_in;
      cand_ff      <= cand_in;
      best_proc_ff <= best_proc_in;
      best_num_ff  <= best_num_in;
      best_den_ff  <= best_den_in;
      cand_num_ff  <= cand_num_in;
      cand_den_ff  <= cand_den_in;
      prod_a_ff    <= prod_a_in;
      prod_b_ff    <= prod_b_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_idle_ff  <= rsp_idle_in;
   end

   // Checks on the sequencer.
   `CTSS_ASSERT(a_cnt0_bound, cnt_ff[0] <= CNT_W'(MAX_PROC), "ready list 0 overflow")
   `CTSS_ASSERT(a_fin_release, (state_ff == ST_RUN_WR && run_fin) |=> !held_ff, "held after end")
   `CTSS_ASSERT(a_stride_release, (state_ff == ST_RUN_WR && pol == POL_STRIDE) |=> !held_ff, "stride held")
   `CTSS_ASSERT_ALWAYS(a_tick_mono, !reset |=> (reset || tick_ff >= $past(tick_ff)), "tick went back")
   `CTSS_ASSERT(a_rsp_from_out, $rose(rsp_tvalid) |-> $past(state_ff == ST_OUT), "stray response")

endmodule
